// ===== src/afc_pkg.sv =====
// Shared types and constants for the box/frustum layer cull pipeline.
// Used by afc_regs, afc_cell and aabb_frustum_layer_cull; depends on nothing.
package afc_pkg;

  localparam int unsigned NumPlanes = 6;
  localparam int unsigned NumAxes   = 3;
  localparam int unsigned NumCells  = NumPlanes * NumAxes;

  // Plane word: nx, ny, nz (Q1.14) low to high, then d (Q11.4) in the top lane
  localparam int unsigned LaneW  = 16;
  localparam int unsigned PlaneW = 64;
  localparam int unsigned MaskW  = 32;
  localparam int unsigned DataW  = 64;
  localparam int unsigned AddrW  = 6;
  localparam int unsigned IdxW   = 3;

  // Three Q.18 products plus d scaled by 2^14 stay within 35 signed bits
  localparam int unsigned ProdW = 2 * LaneW;
  localparam int unsigned AccW  = 35;
  localparam int unsigned DFrac = 14;

  // Register indexes
  localparam logic [IdxW-1:0] RegPlaneLeft = 3'd0;
  localparam logic [IdxW-1:0] RegViewMask  = 3'd6;

  typedef struct packed {
    logic [31:0] entity_index;
    logic [31:0] visible_index;
    logic [31:0] material_id;
    logic [63:0] sort_key;
  } afc_ids_t;

  typedef struct packed {
    afc_ids_t                         ids;
    logic [NumAxes-1:0][LaneW-1:0]    box_min;
    logic [NumAxes-1:0][LaneW-1:0]    box_max;
    logic                             cull;
    logic [AccW-1:0]                  acc;
  } afc_stage_t;

endpackage

// ===== src/aabb_frustum_layer_cull.sv =====
// Top level of the draw cull pipeline: config registers, chain of plane cells,
// output register. Depends on afc_pkg, afc_regs and afc_cell.
//
// Takes one draw per cycle while in_ready_o is high and passes on those whose
// layer mask meets the view mask and whose box is not wholly outside any of
// the six planes, in arrival order; culled draws produce no output
// transaction. The cell chain has one cell per plane and axis (18 cells, one
// multiply-add each) plus an output register, and a kept draw passes through
// every cell register and then the output register.
// Ready runs back through the chain combinationally: an empty cell always
// takes a transaction, so gaps close up behind a stalled output, and once
// every cell is full an output stall drops the input ready in the same cycle.
// Culled draws leave the chain even while the output is stalled.
// Configuration should be written only while no draw is in flight.
module aabb_frustum_layer_cull (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [afc_pkg::AddrW-1:0]     paddr,
  input  logic [afc_pkg::DataW-1:0]     pwdata,
  output logic [afc_pkg::DataW-1:0]     prdata,
  output logic                          pready,
  // Draw input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [31:0]                   entity_index_i,
  input  logic [31:0]                   visible_index_i,
  input  logic [31:0]                   material_id_i,
  input  logic [63:0]                   sort_key_i,
  input  logic [31:0]                   entity_layers_i,
  input  logic signed [15:0]            box_min_x_i,
  input  logic signed [15:0]            box_min_y_i,
  input  logic signed [15:0]            box_min_z_i,
  input  logic signed [15:0]            box_max_x_i,
  input  logic signed [15:0]            box_max_y_i,
  input  logic signed [15:0]            box_max_z_i,
  // Kept draw output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [31:0]                   kept_entity_o,
  output logic [31:0]                   kept_visible_o,
  output logic [31:0]                   kept_material_o,
  output logic [63:0]                   kept_key_o
);

  logic [afc_pkg::NumPlanes-1:0][afc_pkg::PlaneW-1:0] planes;
  logic [afc_pkg::MaskW-1:0]                          view_mask;

  afc_pkg::afc_stage_t                chain_stage [afc_pkg::NumCells+1];
  logic [afc_pkg::NumCells:0]         chain_valid;
  logic [afc_pkg::NumCells:0]         chain_ready;

  logic                               fin_cull;
  logic                               out_valid_q;
  afc_pkg::afc_ids_t                  out_ids_q;

  afc_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .planes_o    (planes),
    .view_mask_o (view_mask)
  );

  // Pack the incoming draw; the layer test sets the cull flag up front
  always_comb begin
    chain_stage[0].ids.entity_index  = entity_index_i;
    chain_stage[0].ids.visible_index = visible_index_i;
    chain_stage[0].ids.material_id   = material_id_i;
    chain_stage[0].ids.sort_key      = sort_key_i;
    chain_stage[0].box_min           = {box_min_z_i, box_min_y_i, box_min_x_i};
    chain_stage[0].box_max           = {box_max_z_i, box_max_y_i, box_max_x_i};
    chain_stage[0].cull              = ~|(entity_layers_i & view_mask);
    chain_stage[0].acc               = '0;
  end

  assign chain_valid[0] = in_valid_i;
  assign in_ready_o     = chain_ready[0];

  // One cell per plane and axis; the first axis of each plane seeds with d
  for (genvar k = 0; k < afc_pkg::NumCells; k++) begin : g_cell
    localparam int unsigned Plane = k / afc_pkg::NumAxes;
    localparam int unsigned Axis  = k % afc_pkg::NumAxes;

    logic [afc_pkg::LaneW-1:0] d_lane;
    logic [afc_pkg::AccW-1:0]  seed;

    assign d_lane = planes[Plane][afc_pkg::PlaneW-1 -: afc_pkg::LaneW];
    assign seed   = {{(afc_pkg::AccW-afc_pkg::LaneW-afc_pkg::DFrac){d_lane[afc_pkg::LaneW-1]}},
                     d_lane, {afc_pkg::DFrac{1'b0}}};

    afc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (chain_valid[k]),
      .ready_o   (chain_ready[k]),
      .stage_i   (chain_stage[k]),
      .valid_o   (chain_valid[k+1]),
      .ready_i   (chain_ready[k+1]),
      .stage_o   (chain_stage[k+1]),
      .normal_i  (planes[Plane][Axis*afc_pkg::LaneW +: afc_pkg::LaneW]),
      .axis_i    (2'(Axis)),
      .restart_i (Axis == 0),
      .seed_i    (seed)
    );
  end

  // Close the last plane; drop culled transactions at once
  assign fin_cull = chain_stage[afc_pkg::NumCells].cull |
                    chain_stage[afc_pkg::NumCells].acc[afc_pkg::AccW-1];
  assign chain_ready[afc_pkg::NumCells] = fin_cull || !out_valid_q || out_ready_i;

  // Hold kept draws in the output register until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= chain_valid[afc_pkg::NumCells] && !fin_cull;
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_valid[afc_pkg::NumCells] && !fin_cull && (!out_valid_q || out_ready_i)) begin
      out_ids_q <= chain_stage[afc_pkg::NumCells].ids;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kept_entity_o   = out_ids_q.entity_index;
  assign kept_visible_o  = out_ids_q.visible_index;
  assign kept_material_o = out_ids_q.material_id;
  assign kept_key_o      = out_ids_q.sort_key;

endmodule

// ===== src/afc_regs.sv =====
// APB-style configuration registers: six frustum planes and the view layer mask.
// Depends on afc_pkg.
module afc_regs (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          psel,
  input  logic                                          penable,
  input  logic                                          pwrite,
  input  logic [afc_pkg::AddrW-1:0]                     paddr,
  input  logic [afc_pkg::DataW-1:0]                     pwdata,
  output logic [afc_pkg::DataW-1:0]                     prdata,
  output logic                                          pready,
  output logic [afc_pkg::NumPlanes-1:0][afc_pkg::PlaneW-1:0] planes_o,
  output logic [afc_pkg::MaskW-1:0]                     view_mask_o
);

  logic [afc_pkg::NumPlanes-1:0][afc_pkg::PlaneW-1:0] planes_q;
  logic [afc_pkg::MaskW-1:0]                          view_mask_q;
  logic [afc_pkg::IdxW-1:0]                           idx;
  logic                                               wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[afc_pkg::AddrW-1:afc_pkg::AddrW-afc_pkg::IdxW];
  assign wr_en  = psel && penable && pwrite;

  // Write on the access phase; ignore indexes past the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      planes_q    <= '0;
      view_mask_q <= '1;
    end else if (wr_en) begin
      if (idx < afc_pkg::RegViewMask) begin
        planes_q[idx] <= pwdata;
      end else if (idx == afc_pkg::RegViewMask) begin
        view_mask_q <= pwdata[afc_pkg::MaskW-1:0];
      end
    end
  end

  // Read back the addressed register
  always_comb begin
    prdata = '0;
    if (idx < afc_pkg::RegViewMask) begin
      prdata = planes_q[idx];
    end else if (idx == afc_pkg::RegViewMask) begin
      prdata = {{(afc_pkg::DataW-afc_pkg::MaskW){1'b0}}, view_mask_q};
    end
  end

  assign planes_o    = planes_q;
  assign view_mask_o = view_mask_q;

endmodule

// ===== src/afc_cell.sv =====
// One pipeline cell: multiplies one normal component by the positive-vertex
// coordinate of one axis and adds it to the running plane sum. Depends on afc_pkg.
module afc_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  afc_pkg::afc_stage_t            stage_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output afc_pkg::afc_stage_t            stage_o,
  input  logic [afc_pkg::LaneW-1:0]      normal_i,
  input  logic [1:0]                     axis_i,
  input  logic                           restart_i,
  input  logic [afc_pkg::AccW-1:0]       seed_i
);

  logic                               valid_q;
  afc_pkg::afc_stage_t                stage_q;
  afc_pkg::afc_stage_t                stage_d;
  logic signed [afc_pkg::LaneW-1:0]   coord;
  logic signed [afc_pkg::ProdW-1:0]   prod;
  logic [afc_pkg::AccW-1:0]           acc_base;
  logic                               cull_base;

  assign ready_o = !valid_q || ready_i;

  // Pick the positive vertex along this axis and form the product
  always_comb begin
    coord = normal_i[afc_pkg::LaneW-1] ? $signed(stage_i.box_min[axis_i])
                                       : $signed(stage_i.box_max[axis_i]);
    prod  = $signed(normal_i) * coord;
  end

  // At a plane boundary, fold the previous plane's sign into the cull flag
  always_comb begin
    acc_base  = restart_i ? seed_i : stage_i.acc;
    cull_base = restart_i ? (stage_i.cull | stage_i.acc[afc_pkg::AccW-1]) : stage_i.cull;
    stage_d      = stage_i;
    stage_d.cull = cull_base;
    stage_d.acc  = acc_base +
                   {{(afc_pkg::AccW-afc_pkg::ProdW){prod[afc_pkg::ProdW-1]}}, prod};
  end

  // Advance when the neighbor takes our transaction or we are empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule
